### src/spi_pkg.sv
package spi_pkg;

  // Fixed field widths of one snapshot.
  localparam int TIME_W = 32;
  localparam int POS_W  = 16;
  localparam int TAG_W  = 8;

  // Command codes carried in the request.
  localparam logic CMD_ADD  = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  typedef struct packed {
    logic [TIME_W-1:0] stamp;
    logic [POS_W-1:0]  x;
    logic [POS_W-1:0]  y;
    logic [TAG_W-1:0]  tag;
  } snap_t;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_SHIFT,
    CELL_INSERT
  } cell_op_t;

  // Control shared by every cell of the buffer chain.
  typedef struct packed {
    cell_op_t op;
    snap_t    fresh;
  } cell_ctl_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ADD_DROP,
    S_ADD_INS,
    S_TICK_DROP,
    S_TICK_EVAL,
    S_DIV,
    S_MUL,
    S_EMIT
  } seq_state_t;

endpackage

### src/spi_cell.sv
module spi_cell
  import spi_pkg::*;
(
  input  logic      clk,
  input  cell_ctl_t ctl,
  input  logic      occupied,
  input  logic      left_keep,
  input  snap_t     left_snap,
  input  snap_t     right_snap,
  output logic      keep,
  output snap_t     snap
);

  snap_t snap_r;
  snap_t snap_nxt;

  // An occupied entry not later than the new stamp stays where it is.
  assign keep = occupied && (snap_r.stamp <= ctl.fresh.stamp);

  // Drop moves everything one place toward the head; insert opens a gap.
  always_comb begin
    snap_nxt = snap_r;
    case (ctl.op)
      CELL_SHIFT: begin
        snap_nxt = right_snap;
      end
      CELL_INSERT: begin
        if (!keep) begin
          if (left_keep) begin
            snap_nxt = ctl.fresh;
          end else begin
            snap_nxt = left_snap;
          end
        end
      end
      default: begin
        snap_nxt = snap_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    snap_r <= snap_nxt;
  end

  assign snap = snap_r;

endmodule

### src/spi_div.sv
module spi_div
  import spi_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [TIME_W-1:0] since,
  input  logic [TIME_W-1:0] dur,
  output logic              done,
  output logic [FRAC_BITS:0] quot
);

  localparam int STEPS = FRAC_BITS + 1;
  localparam int CNT_W = $clog2(STEPS + 1);

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [TIME_W:0]   rem_r, rem_nxt;
  logic [TIME_W-1:0] dur_r, dur_nxt;
  logic [FRAC_BITS:0] q_r, q_nxt;
  logic              fits;
  logic [TIME_W:0]   diff;

  // One restoring quotient bit per cycle, integer bit first.
  assign fits = rem_r >= {1'b0, dur_r};
  assign diff = rem_r - {1'b0, dur_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    dur_nxt  = dur_r;
    q_nxt    = q_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CNT_W'(STEPS);
      rem_nxt  = {1'b0, since};
      dur_nxt  = dur;
      q_nxt    = '0;
    end else if (busy_r) begin
      q_nxt   = {q_r[FRAC_BITS-1:0], fits};
      rem_nxt = fits ? {diff[TIME_W-1:0], 1'b0} : {rem_r[TIME_W-1:0], 1'b0};
      cnt_nxt = cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    dur_r <= dur_nxt;
    q_r   <= q_nxt;
  end

  assign done = done_r;
  assign quot = q_r;

endmodule

### src/snapshot_position_interpolator.sv
// Snapshot position interpolator.
// Input channel (in_valid / in_stall): in_cmd selects add (store a snapshot
// in_stamp, in_pos_x, in_pos_y, in_tag) or tick (interpolate at in_now).
// Result channel (out_valid / out_stall): out_x, out_y, out_tag, out_held,
// one result per tick that finds two or more snapshots after its head drop.
// Snapshots live in a row of DEPTH cells kept sorted by stamp; each cell
// moves its entry to a neighbor on a drop or an insert.
// One request is worked on at a time and in_stall is high while it is busy.
// An add is an insert, preceded by a drop of the head when the buffer is full.
// A tick with fewer than two snapshots ends without leaving idle. Otherwise
// a tick drops the head if the second stamp is before in_now, then
// evaluates; if two snapshots remain it runs the serial fraction divider,
// a multiply step and a step into the output register; a held position
// skips the divider.
// The output register frees the input side: a new request is accepted while
// a result waits. A stalled receiver holds the result, and a following tick
// waits in its last cycle until the output register is free.
// Reset empties the buffer and clears the result valid; no clearing pass.
module snapshot_position_interpolator
  import spi_pkg::*;
#(
  parameter int DEPTH     = 8,
  parameter int FRAC_BITS = 16
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic                    in_cmd,
  input  logic [TIME_W-1:0]       in_stamp,
  input  logic signed [POS_W-1:0] in_pos_x,
  input  logic signed [POS_W-1:0] in_pos_y,
  input  logic [TAG_W-1:0]        in_tag,
  input  logic [TIME_W-1:0]       in_now,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic signed [POS_W-1:0] out_x,
  output logic signed [POS_W-1:0] out_y,
  output logic [TAG_W-1:0]        out_tag,
  output logic                    out_held
);

  localparam int FILL_W = $clog2(DEPTH + 1);
  localparam int FRAC_W = FRAC_BITS + 1;
  localparam int PROD_W = POS_W + FRAC_W;
  localparam int SUM_W  = POS_W + 2;

  seq_state_t state_r, state_nxt;
  logic [FILL_W-1:0] fill_r, fill_nxt;
  snap_t             req_r, req_nxt;
  logic              cmd_r, cmd_nxt;
  logic [TIME_W-1:0] now_r, now_nxt;
  logic              held_r, held_nxt;
  logic [FRAC_W-1:0] frac_r, frac_nxt;
  logic [PROD_W-1:0] prod_x_r, prod_y_r;
  logic              neg_x_r, neg_y_r;
  logic              out_valid_r, out_valid_nxt;
  logic [POS_W-1:0]  out_x_r, out_y_r;
  logic [TAG_W-1:0]  out_tag_r;
  logic              out_held_r;

  cell_ctl_t ctl;
  snap_t     cell_snap [DEPTH];
  logic      cell_keep [DEPTH];

  // Row of buffer cells, head at index zero.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    snap_t l_snap;
    snap_t r_snap;
    logic  l_keep;
    logic  occ;
    if (i == 0) begin : g_head
      assign l_snap = ctl.fresh;
      assign l_keep = 1'b1;
    end else begin : g_body
      assign l_snap = cell_snap[i-1];
      assign l_keep = cell_keep[i-1];
    end
    if (i == DEPTH - 1) begin : g_tail
      assign r_snap = cell_snap[i];
    end else begin : g_next
      assign r_snap = cell_snap[i+1];
    end
    assign occ = fill_r > FILL_W'(i);
    spi_cell u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .occupied   (occ),
      .left_keep  (l_keep),
      .left_snap  (l_snap),
      .right_snap (r_snap),
      .keep       (cell_keep[i]),
      .snap       (cell_snap[i])
    );
  end

  // Values of the two oldest snapshots.
  logic [TIME_W-1:0] t0, t1;
  logic [POS_W-1:0]  x0, x1, y0, y1;
  assign t0 = cell_snap[0].stamp;
  assign t1 = cell_snap[1].stamp;
  assign x0 = cell_snap[0].x;
  assign x1 = cell_snap[1].x;
  assign y0 = cell_snap[0].y;
  assign y1 = cell_snap[1].y;

  // Fraction divider operands.
  logic              div_start, div_done;
  logic [TIME_W-1:0] since_c, dur_c;
  logic [FRAC_W-1:0] div_quot;
  logic              held_c;
  logic              two_plus;

  assign two_plus = fill_r >= FILL_W'(2);
  assign held_c   = (now_r > t1) || (t1 == t0);
  assign since_c  = (now_r > t0) ? (now_r - t0) : '0;
  assign dur_c    = t1 - t0;

  spi_div #(
    .FRAC_BITS (FRAC_BITS)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .since (since_c),
    .dur   (dur_c),
    .done  (div_done),
    .quot  (div_quot)
  );

  // Differences and magnitudes for the multiply cycle.
  logic [POS_W:0]   dx, dy;
  logic [POS_W:0]   mag_x_w, mag_y_w;
  assign dx      = {x1[POS_W-1], x1} - {x0[POS_W-1], x0};
  assign dy      = {y1[POS_W-1], y1} - {y0[POS_W-1], y0};
  assign mag_x_w = dx[POS_W] ? -dx : dx;
  assign mag_y_w = dy[POS_W] ? -dy : dy;

  // Scaled steps and final positions.
  logic [POS_W:0]   step_x, step_y;
  logic [SUM_W-1:0] sum_x, sum_y;
  assign step_x = prod_x_r[FRAC_BITS +: POS_W+1];
  assign step_y = prod_y_r[FRAC_BITS +: POS_W+1];
  assign sum_x  = {{2{x0[POS_W-1]}}, x0}
                + (neg_x_r ? -{1'b0, step_x} : {1'b0, step_x});
  assign sum_y  = {{2{y0[POS_W-1]}}, y0}
                + (neg_y_r ? -{1'b0, step_y} : {1'b0, step_y});

  logic out_free;
  assign out_free = !out_valid_r || !out_stall;

  // Request sequencer.
  always_comb begin
    state_nxt     = state_r;
    fill_nxt      = fill_r;
    req_nxt       = req_r;
    cmd_nxt       = cmd_r;
    now_nxt       = now_r;
    held_nxt      = held_r;
    frac_nxt      = frac_r;
    ctl.op        = CELL_HOLD;
    ctl.fresh     = req_r;
    div_start     = 1'b0;
    out_valid_nxt = out_valid_r && out_stall;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          req_nxt.stamp = in_stamp;
          req_nxt.x     = in_pos_x;
          req_nxt.y     = in_pos_y;
          req_nxt.tag   = in_tag;
          cmd_nxt       = in_cmd;
          now_nxt       = in_now;
          if (in_cmd == CMD_ADD) begin
            state_nxt = (fill_r == FILL_W'(DEPTH)) ? S_ADD_DROP : S_ADD_INS;
          end else if (two_plus) begin
            state_nxt = S_TICK_DROP;
          end
        end
      end
      S_ADD_DROP: begin
        ctl.op    = CELL_SHIFT;
        fill_nxt  = fill_r - FILL_W'(1);
        state_nxt = S_ADD_INS;
      end
      S_ADD_INS: begin
        ctl.op    = CELL_INSERT;
        fill_nxt  = fill_r + FILL_W'(1);
        state_nxt = S_IDLE;
      end
      S_TICK_DROP: begin
        if (t1 < now_r) begin
          ctl.op   = CELL_SHIFT;
          fill_nxt = fill_r - FILL_W'(1);
        end
        state_nxt = S_TICK_EVAL;
      end
      S_TICK_EVAL: begin
        if (!two_plus) begin
          state_nxt = S_IDLE;
        end else if (held_c) begin
          held_nxt  = 1'b1;
          frac_nxt  = FRAC_W'(1) << FRAC_BITS;
          state_nxt = S_MUL;
        end else begin
          held_nxt  = 1'b0;
          div_start = 1'b1;
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        if (div_done) begin
          frac_nxt  = div_quot;
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      fill_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Request, fraction and product registers.
  always_ff @(posedge clk) begin
    req_r  <= req_nxt;
    cmd_r  <= cmd_nxt;
    now_r  <= now_nxt;
    held_r <= held_nxt;
    frac_r <= frac_nxt;
    if (state_r == S_MUL) begin
      prod_x_r <= PROD_W'(mag_x_w[POS_W-1:0]) * PROD_W'(frac_r);
      prod_y_r <= PROD_W'(mag_y_w[POS_W-1:0]) * PROD_W'(frac_r);
      neg_x_r  <= dx[POS_W];
      neg_y_r  <= dy[POS_W];
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (state_r == S_EMIT && out_free) begin
      out_x_r    <= sum_x[POS_W-1:0];
      out_y_r    <= sum_y[POS_W-1:0];
      out_tag_r  <= cell_snap[1].tag;
      out_held_r <= held_r;
    end
  end

  assign in_stall  = state_r != S_IDLE;
  assign out_valid = out_valid_r;
  assign out_x     = out_x_r;
  assign out_y     = out_y_r;
  assign out_tag   = out_tag_r;
  assign out_held  = out_held_r;

  // The buffer never holds more entries than it has cells.
  assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FILL_W'(DEPTH))
    else $error("fill count exceeds buffer depth");

  // The two oldest snapshots are in stamp order when a tick evaluates.
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_TICK_EVAL && two_plus) |-> (t0 <= t1))
    else $error("snapshot buffer out of order");

  // A result becomes valid only from the emit step.
  assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_EMIT))
    else $error("result valid without emit");

  // The divider finishes only while the sequencer waits for it.
  assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == S_DIV))
    else $error("divider done outside divide step");

  // Only a tick request reaches the divider.
  assert property (@(posedge clk) disable iff (!rst_n)
    div_start |-> (cmd_r == CMD_TICK))
    else $error("divider started by an add request");

endmodule
